// ----- design/wag_pkg.sv -----
`default_nettype none

package wag_pkg;

  typedef logic [1:0] cell_t;

  localparam cell_t CELL_EMPTY     = 2'd0;
  localparam cell_t CELL_CONDUCTOR = 2'd1;
  localparam cell_t CELL_HEAD      = 2'd2;
  localparam cell_t CELL_TAIL      = 2'd3;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_STEP  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  localparam logic CFG_COLUMNS = 1'b0;
  localparam logic CFG_ROWS    = 1'b1;

  localparam logic [7:0] RST_COLUMNS = 8'd100;
  localparam logic [6:0] RST_ROWS    = 7'd50;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_READ,
    S_STEP,
    S_CLEAR,
    S_FINISH
  } state_t;

  // 3x3 neighborhood as seen by the rule: center value plus head flags of
  // the eight neighbors, already masked at the area edges.
  typedef struct packed {
    cell_t      center;
    logic [7:0] heads;
  } wag_window_t;

  function automatic logic is_head(cell_t v);
    return v == CELL_HEAD;
  endfunction

endpackage

`default_nettype wire

// ----- design/wag_cmd_if.sv -----
`default_nettype none

interface wag_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [6:0] column;
  logic [5:0] row;
  logic [1:0] cell_value;

  modport source (output valid, opcode, column, row, cell_value, input ready);
  modport sink   (input valid, opcode, column, row, cell_value, output ready);
endinterface

`default_nettype wire

// ----- design/wag_res_if.sv -----
`default_nettype none

interface wag_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] read_value;
  logic [1:0] done_opcode;

  modport source (output valid, read_value, done_opcode, input ready);
  modport sink   (input valid, read_value, done_opcode, output ready);
endinterface

`default_nettype wire

// ----- design/wag_ram.sv -----
`default_nettype none

module wag_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- design/wag_cell.sv -----
`default_nettype none

module wag_cell
  import wag_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  clr,
  input  wire logic  en,
  input  wire cell_t din,
  output cell_t      dout
);

  // clear wins: the chain starts every generation from empty cells
  always_ff @(posedge clk) begin
    if (clr) begin
      dout <= CELL_EMPTY;
    end else if (en) begin
      dout <= din;
    end
  end

endmodule

`default_nettype wire

// ----- design/wag_rule.sv -----
`default_nettype none

module wag_rule
  import wag_pkg::*;
(
  input  wire wag_window_t win,
  output cell_t            next_value
);

  logic [3:0] head_count;

  always_comb begin
    head_count = 4'd0;
    for (int i = 0; i < 8; i++) begin
      head_count = head_count + 4'(win.heads[i]);
    end
  end

  always_comb begin
    case (win.center)
      CELL_HEAD:      next_value = CELL_TAIL;
      CELL_TAIL:      next_value = CELL_CONDUCTOR;
      CELL_CONDUCTOR: next_value = (head_count == 4'd1 || head_count == 4'd2) ?
                                   CELL_HEAD : CELL_CONDUCTOR;
      default:        next_value = CELL_EMPTY;
    endcase
  end

endmodule

`default_nettype wire

// ----- design/wire_automaton_grid_engine_core.sv -----
`default_nettype none

// Wireworld board engine.
// Commands arrive on the cmd channel (valid/ready); each one completes with
// exactly one transaction on the res channel, carrying the echoed opcode and,
// for an in-area read, the cell value (otherwise 0). Area size is set through
// the write port cfg_we/cfg_index/cfg_data; the user must write it only while
// no command is in flight, as the block itself does not enforce this.
// A clear sweeps the whole board, not only the area in use. A step on an
// empty area finishes without streaming the board; otherwise it works through
// rows_in_use rows, capped at MAX_ROWS.
// The step time is set by the single board RAM port pair: every column slot
// of every active row is streamed once through a 2*MAX_COLUMNS+3 cell chain.
// One command is worked on at a time; the next is taken once the result has
// been moved into the output register, so a stalled receiver holds one
// result while the engine takes the next command, and a second finished
// result waits until the first transaction completes.
// After reset the engine sweeps the whole board to empty, one cell per cycle,
// with cmd.ready low; config writes still work.

module wire_automaton_grid_engine_core
  import wag_pkg::*;
#(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_ROWS    = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  wag_cmd_if.sink         cmd,
  wag_res_if.source       res,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_data
);

  localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int LW    = $clog2(MAX_COLUMNS * (MAX_ROWS + 2));
  localparam int CW    = $clog2(MAX_COLUMNS);
  localparam int CE    = $clog2(MAX_COLUMNS + 1);
  localparam int RW    = $clog2(MAX_ROWS + 2);
  localparam int RE    = $clog2(MAX_ROWS + 1);
  localparam int CRW   = $clog2(MAX_ROWS);
  localparam int CHAIN = 2 * MAX_COLUMNS + 3;

  // chain tap positions around the center cell
  localparam int T_BR = 0;
  localparam int T_BC = 1;
  localparam int T_BL = 2;
  localparam int T_MR = MAX_COLUMNS;
  localparam int T_MC = MAX_COLUMNS + 1;
  localparam int T_ML = MAX_COLUMNS + 2;
  localparam int T_TR = 2 * MAX_COLUMNS;
  localparam int T_TC = 2 * MAX_COLUMNS + 1;
  localparam int T_TL = 2 * MAX_COLUMNS + 2;

  state_t state, state_next;

  logic [7:0]    columns_in_use;
  logic [6:0]    rows_in_use;
  logic [CE-1:0] cols_eff;
  logic [RE-1:0] rows_eff;

  logic [AW-1:0]  sw;
  logic [LW-1:0]  raddr;
  logic [CW-1:0]  rcol;
  logic [RW-1:0]  rrow;
  logic           cact;
  logic [CW-1:0]  ccol;
  logic [CRW-1:0] crow;
  logic [AW-1:0]  caddr;
  logic           pvalid;
  logic           inarea_d;
  logic           hit;
  cell_t          pend_val;
  logic [1:0]     pend_op;
  logic           res_valid;
  cell_t          res_rv;
  logic [1:0]     res_op;

  logic          accept;
  logic          in_area;
  logic [AW-1:0] host_addr;
  logic          sweep_last;
  logic          step_last;
  logic          area_empty;
  logic          out_free;
  logic          rd_inarea;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  cell_t         ram_wdata;
  logic [AW-1:0] ram_raddr;
  cell_t         ram_rdata;

  cell_t       push;
  cell_t       tap [CHAIN];
  wag_window_t win;
  cell_t       new_value;

  // effective area, saturated at the board size
  assign cols_eff = (32'(columns_in_use) > MAX_COLUMNS) ? CE'(MAX_COLUMNS)
                                                        : CE'(columns_in_use);
  assign rows_eff = (32'(rows_in_use) > MAX_ROWS) ? RE'(MAX_ROWS) : RE'(rows_in_use);
  assign area_empty = (cols_eff == '0) || (rows_eff == '0);

  assign accept    = cmd.valid && cmd.ready;
  assign in_area   = (32'(cmd.column) < 32'(cols_eff)) && (32'(cmd.row) < 32'(rows_eff));
  assign host_addr = AW'(32'(cmd.row) * MAX_COLUMNS + 32'(cmd.column));
  assign out_free  = !res_valid || res.ready;

  assign sweep_last = (sw == AW'(DEPTH - 1));
  assign step_last  = cact && (ccol == CW'(MAX_COLUMNS - 1))
                      && ((RE'(crow) + RE'(1)) == rows_eff);
  assign rd_inarea  = (rrow < RW'(rows_eff)) && (CE'(rcol) < cols_eff);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_INIT:  if (sweep_last) state_next = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          case (op_t'(cmd.opcode))
            OP_WRITE: state_next = S_FINISH;
            OP_READ:  state_next = S_READ;
            OP_STEP:  state_next = area_empty ? S_FINISH : S_STEP;
            OP_CLEAR: state_next = S_CLEAR;
            default:  state_next = S_FINISH;
          endcase
        end
      end
      S_READ:   state_next = S_FINISH;
      S_STEP:   if (step_last) state_next = S_FINISH;
      S_CLEAR:  if (sweep_last) state_next = S_FINISH;
      S_FINISH: if (out_free) state_next = S_IDLE;
      default:  state_next = S_INIT;
    endcase
  end

  // outputs: RAM port use and handshake
  always_comb begin
    cmd.ready = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = host_addr;
    ram_wdata = cmd.cell_value;
    ram_raddr = host_addr;
    case (state)
      S_INIT, S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = sw;
        ram_wdata = CELL_EMPTY;
      end
      S_IDLE: begin
        cmd.ready = 1'b1;
        ram_we    = cmd.valid && in_area && (cmd.opcode == OP_WRITE);
      end
      S_STEP: begin
        ram_raddr = raddr[AW-1:0];
        ram_we    = cact && (CE'(ccol) < cols_eff);
        ram_waddr = caddr;
        ram_wdata = new_value;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      columns_in_use <= RST_COLUMNS;
      rows_in_use    <= RST_ROWS;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COLUMNS: columns_in_use <= cfg_data;
        CFG_ROWS:    rows_in_use    <= cfg_data[6:0];
        default:     columns_in_use <= columns_in_use;
      endcase
    end
  end

  // control, counters and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      sw        <= '0;
      raddr     <= '0;
      rcol      <= '0;
      rrow      <= '0;
      cact      <= 1'b0;
      ccol      <= '0;
      crow      <= '0;
      caddr     <= '0;
      pvalid    <= 1'b0;
      inarea_d  <= 1'b0;
      hit       <= 1'b0;
      pend_val  <= CELL_EMPTY;
      pend_op   <= OP_WRITE;
      res_valid <= 1'b0;
      res_rv    <= CELL_EMPTY;
      res_op    <= OP_WRITE;
    end else begin
      state    <= state_next;
      pvalid   <= (state == S_STEP);
      inarea_d <= rd_inarea;

      if (state == S_INIT || state == S_CLEAR) begin
        sw <= sw + AW'(1);
      end

      if (accept) begin
        pend_op  <= cmd.opcode;
        pend_val <= CELL_EMPTY;
        hit      <= in_area && (cmd.opcode == OP_READ);
        sw       <= '0;
        raddr    <= '0;
        rcol     <= '0;
        rrow     <= '0;
        cact     <= 1'b0;
        ccol     <= '0;
        crow     <= '0;
        caddr    <= '0;
      end

      if (state == S_READ) begin
        pend_val <= hit ? ram_rdata : CELL_EMPTY;
      end

      if (state == S_STEP) begin
        // read side walks ahead; center trails by MAX_COLUMNS+3 slots
        raddr <= raddr + LW'(1);
        if (rcol == CW'(MAX_COLUMNS - 1)) begin
          rcol <= '0;
          rrow <= rrow + RW'(1);
        end else begin
          rcol <= rcol + CW'(1);
        end
        if (step_last) begin
          cact <= 1'b0;
        end else if (raddr == LW'(MAX_COLUMNS + 2)) begin
          cact <= 1'b1;
        end
        if (cact) begin
          caddr <= caddr + AW'(1);
          if (ccol == CW'(MAX_COLUMNS - 1)) begin
            ccol <= '0;
            crow <= crow + CRW'(1);
          end else begin
            ccol <= ccol + CW'(1);
          end
        end
      end

      // load the output slot, or drop the result once it has been taken
      if (state == S_FINISH && out_free) begin
        res_valid <= 1'b1;
        res_rv    <= pend_val;
        res_op    <= pend_op;
      end else if (res_valid && res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  assign res.valid       = res_valid;
  assign res.read_value  = res_rv;
  assign res.done_opcode = res_op;

  wag_ram #(
    .WIDTH(2),
    .DEPTH(DEPTH)
  ) u_board (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Cell chain: each fetched cell enters at the head and moves one place per
  // fetch, so three rows of old values sit around the center tap. Cells
  // outside the area enter as empty, which keeps them from counting as heads.
  assign push = inarea_d ? ram_rdata : CELL_EMPTY;

  for (genvar g = 0; g < CHAIN; g++) begin : g_chain
    if (g == 0) begin : g_head
      wag_cell u_cell (
        .clk (clk),
        .clr (accept),
        .en  (pvalid),
        .din (push),
        .dout(tap[g])
      );
    end else begin : g_body
      wag_cell u_cell (
        .clk (clk),
        .clr (accept),
        .en  (pvalid),
        .din (tap[g-1]),
        .dout(tap[g])
      );
    end
  end

  // mask the column neighbors that wrap around a row boundary
  always_comb begin
    logic left_ok;
    logic right_ok;
    left_ok    = (ccol != '0);
    right_ok   = (ccol != CW'(MAX_COLUMNS - 1));
    win.center = tap[T_MC];
    win.heads  = {is_head(tap[T_TL]) && left_ok,
                  is_head(tap[T_TC]),
                  is_head(tap[T_TR]) && right_ok,
                  is_head(tap[T_ML]) && left_ok,
                  is_head(tap[T_MR]) && right_ok,
                  is_head(tap[T_BL]) && left_ok,
                  is_head(tap[T_BC]),
                  is_head(tap[T_BR]) && right_ok};
  end

  wag_rule u_rule (
    .win       (win),
    .next_value(new_value)
  );

  // one command in flight: no accept right after an accept
  assert property (@(posedge clk) disable iff (rst) accept |=> !cmd.ready)
    else $error("command accepted while previous command busy");

  // write-back position trails the fetch position by a fixed distance
  assert property (@(posedge clk) disable iff (rst)
    (state == S_STEP && cact) |-> (raddr == LW'(caddr) + LW'(MAX_COLUMNS + 3)))
    else $error("step fetch and write-back out of alignment");

  // only a read returns a nonzero value
  assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.done_opcode != OP_READ) |-> (res.read_value == CELL_EMPTY))
    else $error("nonzero value on a non-read result");

  // a finished result is never dropped while the receiver stalls
  assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && res_valid && !res.ready) |=> (state == S_FINISH))
    else $error("result left finish state while output slot busy");

endmodule

`default_nettype wire
